/* design/irtfpe_pkg.sv */
package irtfpe_pkg;

    localparam int unsigned FRAME_BITS = 13;
    localparam int unsigned DUR_W      = 16;
    localparam int unsigned ID_W       = 8;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [POS_W-1:0] LAST_BIT = 4'd12;
    localparam logic [POS_W-1:0] GAP_POS  = 4'd13;

    localparam logic [CFG_IDX_W-1:0] CFG_ID         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_IDLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_PULSE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_IDLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PULSE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP  = 3'd5;

    localparam logic [ID_W-1:0]  RST_ID         = 8'd0;
    localparam logic [DUR_W-1:0] RST_ONE_IDLE   = 16'd450;
    localparam logic [DUR_W-1:0] RST_ONE_PULSE  = 16'd320;
    localparam logic [DUR_W-1:0] RST_ZERO_IDLE  = 16'd220;
    localparam logic [DUR_W-1:0] RST_ZERO_PULSE = 16'd580;
    localparam logic [DUR_W-1:0] RST_FRAME_GAP  = 16'd50000;

    typedef struct packed {
        logic [ID_W-1:0]  transponder_id;
        logic [DUR_W-1:0] one_idle_ticks;
        logic [DUR_W-1:0] one_pulse_ticks;
        logic [DUR_W-1:0] zero_idle_ticks;
        logic [DUR_W-1:0] zero_pulse_ticks;
        logic [DUR_W-1:0] frame_gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] id;
    } t_id_wr;

    typedef struct packed {
        logic             carrier_on;
        logic             frame_end;
        logic [POS_W-1:0] bit_position;
    } t_result;

    // start 1, id MSB first, tail 0101
    function automatic logic [FRAME_BITS-1:0] build_frame(input logic [ID_W-1:0] id);
        return {1'b1, id, 4'b0101};
    endfunction

    function automatic logic [DUR_W-1:0] at_least_one(input logic [DUR_W-1:0] v);
        return (v == '0) ? {{(DUR_W-1){1'b0}}, 1'b1} : v;
    endfunction

endpackage

/* design/irtfpe_cfg.sv */
module irtfpe_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [irtfpe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [irtfpe_pkg::DUR_W-1:0]       i_cfg_data,
    output irtfpe_pkg::t_cfg                   o_cfg,
    output irtfpe_pkg::t_id_wr                 o_id_wr
);

    irtfpe_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.transponder_id   <= irtfpe_pkg::RST_ID;
            r_cfg.one_idle_ticks   <= irtfpe_pkg::RST_ONE_IDLE;
            r_cfg.one_pulse_ticks  <= irtfpe_pkg::RST_ONE_PULSE;
            r_cfg.zero_idle_ticks  <= irtfpe_pkg::RST_ZERO_IDLE;
            r_cfg.zero_pulse_ticks <= irtfpe_pkg::RST_ZERO_PULSE;
            r_cfg.frame_gap_ticks  <= irtfpe_pkg::RST_FRAME_GAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                irtfpe_pkg::CFG_ID:         r_cfg.transponder_id   <= i_cfg_data[irtfpe_pkg::ID_W-1:0];
                irtfpe_pkg::CFG_ONE_IDLE:   r_cfg.one_idle_ticks   <= i_cfg_data;
                irtfpe_pkg::CFG_ONE_PULSE:  r_cfg.one_pulse_ticks  <= i_cfg_data;
                irtfpe_pkg::CFG_ZERO_IDLE:  r_cfg.zero_idle_ticks  <= i_cfg_data;
                irtfpe_pkg::CFG_ZERO_PULSE: r_cfg.zero_pulse_ticks <= i_cfg_data;
                irtfpe_pkg::CFG_FRAME_GAP:  r_cfg.frame_gap_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg      = r_cfg;
    assign o_id_wr.we = i_cfg_we && (i_cfg_index == irtfpe_pkg::CFG_ID);
    assign o_id_wr.id = i_cfg_data[irtfpe_pkg::ID_W-1:0];

endmodule

/* design/irtfpe_seq.sv */
module irtfpe_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_tick,
    input  irtfpe_pkg::t_cfg      i_cfg,
    input  irtfpe_pkg::t_id_wr    i_id_wr,
    output irtfpe_pkg::t_result   o_result
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PULSE = 2'd1,
        PH_GAP   = 2'd2
    } t_phase;

    t_phase                                r_phase,    n_phase;
    logic [irtfpe_pkg::DUR_W-1:0]          r_tick_cnt, n_tick_cnt;
    logic [irtfpe_pkg::POS_W-1:0]          r_bit_cnt,  n_bit_cnt;
    logic [irtfpe_pkg::FRAME_BITS-1:0]     r_shift,    n_shift;

    logic                                  cur_bit;
    logic [irtfpe_pkg::DUR_W-1:0]          period_len;
    logic [irtfpe_pkg::DUR_W:0]            cnt_inc;
    logic                                  period_done;
    logic                                  at_frame_start;

    assign cur_bit        = r_shift[irtfpe_pkg::FRAME_BITS-1];
    assign cnt_inc        = {1'b0, r_tick_cnt} + {{irtfpe_pkg::DUR_W{1'b0}}, 1'b1};
    assign period_done    = cnt_inc >= {1'b0, period_len};
    assign at_frame_start = (r_phase == PH_IDLE) && (r_bit_cnt == '0) && (r_tick_cnt == '0);

    always_comb begin
        unique case (r_phase)
            PH_IDLE:  period_len = irtfpe_pkg::at_least_one(
                          cur_bit ? i_cfg.one_idle_ticks : i_cfg.zero_idle_ticks);
            PH_PULSE: period_len = irtfpe_pkg::at_least_one(
                          cur_bit ? i_cfg.one_pulse_ticks : i_cfg.zero_pulse_ticks);
            default:  period_len = irtfpe_pkg::at_least_one(i_cfg.frame_gap_ticks);
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_tick_cnt = r_tick_cnt;
        n_bit_cnt  = r_bit_cnt;
        n_shift    = r_shift;

        o_result.carrier_on   = (r_phase == PH_PULSE);
        o_result.frame_end    = 1'b0;
        o_result.bit_position = ((r_phase == PH_IDLE) || (r_phase == PH_PULSE)) ?
                                r_bit_cnt : irtfpe_pkg::GAP_POS;

        if (i_step && i_tick) begin
            if (period_done) begin
                n_tick_cnt = '0;
                unique case (r_phase)
                    PH_IDLE: begin
                        n_phase = PH_PULSE;
                    end
                    PH_PULSE: begin
                        if (r_bit_cnt >= irtfpe_pkg::LAST_BIT) begin
                            n_phase   = PH_GAP;
                            n_bit_cnt = irtfpe_pkg::GAP_POS;
                        end else begin
                            n_phase   = PH_IDLE;
                            n_bit_cnt = r_bit_cnt + 4'd1;
                            n_shift   = {r_shift[irtfpe_pkg::FRAME_BITS-2:0], 1'b0};
                        end
                    end
                    default: begin
                        o_result.frame_end = 1'b1;
                        n_phase            = PH_IDLE;
                        n_bit_cnt          = '0;
                        n_shift            = irtfpe_pkg::build_frame(i_cfg.transponder_id);
                    end
                endcase
            end else begin
                n_tick_cnt = cnt_inc[irtfpe_pkg::DUR_W-1:0];
            end
        end else if (i_id_wr.we && at_frame_start) begin
            n_shift = irtfpe_pkg::build_frame(i_id_wr.id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_tick_cnt <= '0;
            r_bit_cnt  <= '0;
            r_shift    <= irtfpe_pkg::build_frame(irtfpe_pkg::RST_ID);
        end else begin
            r_phase    <= n_phase;
            r_tick_cnt <= n_tick_cnt;
            r_bit_cnt  <= n_bit_cnt;
            r_shift    <= n_shift;
        end
    end

    a_gap_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_GAP) |-> (r_bit_cnt == irtfpe_pkg::GAP_POS))
        else $error("gap phase without gap position");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_GAP) |-> (r_bit_cnt <= irtfpe_pkg::LAST_BIT))
        else $error("bit counter past last frame bit");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.frame_end) |=>
        (r_phase == PH_IDLE && r_bit_cnt == '0 && r_tick_cnt == '0))
        else $error("frame end did not restart the frame");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_tick) |=>
        ($stable(r_phase) && $stable(r_tick_cnt) && $stable(r_bit_cnt)))
        else $error("state moved on a zero tick");

endmodule

/* design/ir_transponder_frame_pulse_encoder_core.sv */
// Infrared transponder frame pulse encoder.
// Input channel: one word per microsecond slot, i_tick = 1 advances the frame
// timing, i_tick = 0 leaves the frame timing untouched. Every accepted word yields
// exactly one output word: carrier enable, frame-end marker and the frame bit
// position (0..12, 13 during the inter-frame gap), all describing the tick
// that was consumed.
// o_out_valid rises in the cycle after input accept. Throughput: one word per
// cycle while o_in_stall is low; the per-tick update is a single 16-bit
// increment and compare between the state registers and the output register.
// Stall: o_in_stall rises only while the output register is full and
// i_out_stall is high, so a new word is taken in the same cycle the previous
// result leaves.
// Config: write enable, index 0..5 (id, one idle, one pulse, zero idle,
// zero pulse, frame gap), data 16 bits; write only while idle. A new id is
// loaded at the next frame start, or at once if the frame has not begun.
// Reset (synchronous, active low): registers take their default durations,
// id 0, timing sits at the start of bit 0's idle period, output empty.
module ir_transponder_frame_pulse_encoder_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_tick,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_carrier_on,
    output logic                               o_frame_end,
    output logic [irtfpe_pkg::POS_W-1:0]       o_bit_position,
    input  logic                               i_cfg_we,
    input  logic [irtfpe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [irtfpe_pkg::DUR_W-1:0]       i_cfg_data
);

    irtfpe_pkg::t_cfg    cfg;
    irtfpe_pkg::t_id_wr  id_wr;
    irtfpe_pkg::t_result result;
    irtfpe_pkg::t_result r_out;
    logic                r_out_valid;
    logic                in_accept;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    irtfpe_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_id_wr     (id_wr)
    );

    irtfpe_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_accept),
        .i_tick   (i_tick),
        .i_cfg    (cfg),
        .i_id_wr  (id_wr),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_carrier_on   = r_out.carrier_on;
    assign o_frame_end    = r_out.frame_end;
    assign o_bit_position = r_out.bit_position;

endmodule
